// File: rtl/lss_pkg.sv
// Shared constants and types for the largest-square scan block.
// No dependencies; every other file in rtl/ except lss_ram refers to it by scoped name.
package lss_pkg;

  // Field widths of the result beat and of the configuration registers.
  localparam int CELL_W = 11;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;

  // Largest value a cell can hold; longer runs saturate here.
  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

  // Default grid limits and the reset value of both size registers.
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Register file: two 32-bit registers, selected by address bit 2.
  localparam int BUS_W     = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_SEL_B = 2;
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  // Depth of the queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Per-cell flags that travel with the coordinates through the queue.
  typedef struct packed {
    logic open;
    logic done;
  } lss_flags_t;

endpackage

// File: rtl/lss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the line buffer of the back end.
module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read in the same cycle as a write to the same entry returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lss_front.sv
// Front end: accepts cell beats and assigns each its row, column and
// end-of-grid flag. Depends on lss_pkg; feeds lss_queue.
module lss_front #(
  parameter int MAX_COLS = lss_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lss_pkg::DEF_MAX_ROWS,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [lss_pkg::CFG_W-1:0] cols_cfg,
  input  logic [lss_pkg::CFG_W-1:0] rows_cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cell_open,
  input  logic                    q_full,
  output logic                    push,
  output logic [CW-1:0]           push_col,
  output logic [RW-1:0]           push_row,
  output lss_pkg::lss_flags_t     push_flags
);

  localparam int CEW = CW + 1;
  localparam int REW = RW + 1;

  logic [CW-1:0]  col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]  row_cnt_r, row_cnt_nxt;
  logic [CEW-1:0] cols_eff, col_inc;
  logic [REW-1:0] rows_eff, row_pre, row_inc;
  logic           wrap_pre, done;
  logic [CW-1:0]  col_cur;
  logic [RW-1:0]  row_cur;

  // Effective grid size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (cols_cfg == '0) begin
      cols_eff = CEW'(1);
    end else if (32'(cols_cfg) > 32'(MAX_COLS)) begin
      cols_eff = CEW'(MAX_COLS);
    end else begin
      cols_eff = CEW'(cols_cfg);
    end
    if (rows_cfg == '0) begin
      rows_eff = REW'(1);
    end else if (32'(rows_cfg) > 32'(MAX_ROWS)) begin
      rows_eff = REW'(MAX_ROWS);
    end else begin
      rows_eff = REW'(rows_cfg);
    end
  end

  // Position of this cell; counters left out of range by a size change wrap first.
  always_comb begin
    wrap_pre = {1'b0, col_cnt_r} >= cols_eff;
    col_cur  = wrap_pre ? '0 : col_cnt_r;
    row_pre  = wrap_pre ? ({1'b0, row_cnt_r} + REW'(1)) : {1'b0, row_cnt_r};
    row_cur  = (row_pre >= rows_eff) ? '0 : row_pre[RW-1:0];
    done     = ({1'b0, row_cur} == rows_eff - REW'(1)) &&
               ({1'b0, col_cur} == cols_eff - CEW'(1));
  end

  // Raster advance to the next cell, back to the origin after the last one.
  always_comb begin
    col_inc = {1'b0, col_cur} + CEW'(1);
    row_inc = {1'b0, row_cur} + REW'(1);
    if (done) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (col_inc >= cols_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= rows_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (push) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // A beat is taken whenever the queue has room.
  assign in_stall        = q_full;
  assign push            = in_valid && !q_full;
  assign push_col        = col_cur;
  assign push_row        = row_cur;
  assign push_flags.open = in_cell_open;
  assign push_flags.done = done;

endmodule

// File: rtl/lss_queue.sv
// Small register queue that decouples the front end from the back end.
// Depends on lss_pkg for its default depth.
module lss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lss_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [PW:0]      cnt_r;

  assign full     = cnt_r == (PW + 1)'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = slot_r[rptr_r];

  // Storage is written only at the write pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (32'(wptr_r) == DEPTH - 1) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (32'(rptr_r) == DEPTH - 1) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/lss_back.sv
// Back end: line-buffer lookup, square-size recurrence, best tracking and
// the output register. Depends on lss_pkg and lss_ram; fed by lss_queue.
module lss_back #(
  parameter int MAX_COLS = lss_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lss_pkg::DEF_MAX_ROWS,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic [CW-1:0]             q_col,
  input  logic [RW-1:0]             q_row,
  input  lss_pkg::lss_flags_t       q_flags,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lss_pkg::CELL_W-1:0] out_cell_square,
  output logic [lss_pkg::CELL_W-1:0] out_best_size,
  output logic [lss_pkg::POS_W-1:0]  out_best_row,
  output logic [lss_pkg::POS_W-1:0]  out_best_col,
  output logic                      out_grid_done
);

  localparam int VW = lss_pkg::CELL_W;

  // Execute stage holding the cell whose line-buffer read is in flight.
  logic                ex_v_r;
  logic [CW-1:0]       ex_col_r;
  logic [RW-1:0]       ex_row_r;
  lss_pkg::lss_flags_t ex_flags_r;
  logic                exec_adv, exec_free;

  // Neighbor values, last line-buffer write and best square.
  logic [VW-1:0] left_r, diag_r;
  logic          lw_v_r;
  logic [CW-1:0] lw_addr_r;
  logic [VW-1:0] lw_data_r;
  logic [VW-1:0] best_r;
  logic [RW-1:0] best_row_r;
  logic [CW-1:0] best_col_r;

  // Output register.
  logic          out_valid_r;
  logic [VW-1:0] out_cell_r, out_size_r;
  logic [lss_pkg::POS_W-1:0] out_row_r, out_col_r;
  logic          out_done_r;

  logic [VW-1:0] ram_rdata, up, min_lu, min3, val;
  logic          best_upd;
  logic [VW-1:0] best_now;
  logic [RW-1:0] best_row_now;
  logic [CW-1:0] best_col_now;

  // Stage advance: the execute stage moves when the output register frees up.
  assign exec_adv  = ex_v_r && (!out_valid_r || !out_stall);
  assign exec_free = !ex_v_r || exec_adv;
  assign q_pop     = !q_empty && exec_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0;
    end else if (exec_free) begin
      ex_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_col_r   <= q_col;
      ex_row_r   <= q_row;
      ex_flags_r <= q_flags;
    end
  end

  // Line buffer of the previous row: read on pop, written as the cell retires.
  lss_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (exec_adv),
    .waddr (ex_col_r),
    .wdata (val),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (ram_rdata)
  );

  // The write retired in the same cycle as the read is not in the RAM data yet.
  assign up = (lw_v_r && (lw_addr_r == ex_col_r)) ? lw_data_r : ram_rdata;

  // Square recurrence with saturation at the largest value.
  always_comb begin
    min_lu = (left_r < up) ? left_r : up;
    min3   = (diag_r < min_lu) ? diag_r : min_lu;
    if (!ex_flags_r.open) begin
      val = '0;
    end else if ((ex_row_r == '0) || (ex_col_r == '0)) begin
      val = VW'(1);
    end else if (min3 == lss_pkg::CELL_MAX) begin
      val = lss_pkg::CELL_MAX;
    end else begin
      val = min3 + VW'(1);
    end
  end

  // Only a strictly larger value moves the best position.
  always_comb begin
    best_upd     = val > best_r;
    best_now     = best_upd ? val : best_r;
    best_row_now = best_upd ? ex_row_r : best_row_r;
    best_col_now = best_upd ? ex_col_r : best_col_r;
  end

  // Running state; the best square clears after the last cell of a grid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      lw_v_r      <= 1'b0;
      best_r      <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec_adv || (out_valid_r && out_stall);
      if (exec_adv) begin
        left_r <= val;
        diag_r <= up;
        lw_v_r <= 1'b1;
        if (ex_flags_r.done) begin
          best_r     <= '0;
          best_row_r <= '0;
          best_col_r <= '0;
        end else begin
          best_r     <= best_now;
          best_row_r <= best_row_now;
          best_col_r <= best_col_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_adv) begin
      lw_addr_r  <= ex_col_r;
      lw_data_r  <= val;
      out_cell_r <= val;
      out_size_r <= best_now;
      out_row_r  <= lss_pkg::POS_W'(best_row_now);
      out_col_r  <= lss_pkg::POS_W'(best_col_now);
      out_done_r <= ex_flags_r.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_square = out_cell_r;
  assign out_best_size   = out_size_r;
  assign out_best_row    = out_row_r;
  assign out_best_col    = out_col_r;
  assign out_grid_done   = out_done_r;

  // The best square is cleared once the last cell of a grid retires.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_adv && ex_flags_r.done) |=> (best_r == '0 && best_row_r == '0 && best_col_r == '0))
    else $error("best square not cleared after end of grid");

  // Within a grid the best size never shrinks.
  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_adv && !ex_flags_r.done) |=> (best_r >= $past(best_r)))
    else $error("best size decreased within a grid");

  // A delivered cell value never exceeds the best size delivered with it.
  a_cell_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cell_r <= out_size_r))
    else $error("cell value above best size");

  // A blocked cell leaves a zero left neighbor for the next cell.
  a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_adv && !ex_flags_r.open) |=> (left_r == '0))
    else $error("blocked cell produced a nonzero value");

endmodule

// File: rtl/largest_square_scan.sv
// Top level of the largest-square scan: register file, front end, queue
// and back end. Depends on lss_pkg, lss_front, lss_queue and lss_back.
//
// The block takes one grid cell per beat in raster order and returns one
// result beat per cell: the side of the largest open square ending at that
// cell, the best side so far in the grid with its bottom-right corner, and
// a flag on the last cell, after which the next cell starts a new grid. It
// sustains one cell per clock while nothing stalls; an accepted cell passes
// through the queue and the execute stage into the output register behind
// out_valid. The rate is set by the line buffer, a MAX_COLS by 11-bit RAM
// that takes one read and one write per cycle. A four-entry queue absorbs
// output stalls; in_stall rises only when it is full. grid_cols (address 0)
// and grid_rows (address 4) are to be written while the block is idle; the
// block itself does not enforce this. Zero acts as one and a value above the
// maximum acts as the maximum. Line-buffer entries are undefined after reset,
// which only matters if grid_cols is raised in the middle of a grid.
module largest_square_scan #(
  parameter int MAX_COLS = lss_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lss_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lss_pkg::ADDR_W-1:0]  paddr,
  input  logic [lss_pkg::BUS_W-1:0]   pwdata,
  output logic [lss_pkg::BUS_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cell_open,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lss_pkg::CELL_W-1:0]  out_cell_square,
  output logic [lss_pkg::CELL_W-1:0]  out_best_size,
  output logic [lss_pkg::POS_W-1:0]   out_best_row,
  output logic [lss_pkg::POS_W-1:0]   out_best_col,
  output logic                        out_grid_done
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int FW = $bits(lss_pkg::lss_flags_t);
  localparam int QW = FW + RW + CW;

  logic [lss_pkg::CFG_W-1:0] grid_cols_r, grid_rows_r;
  logic                      cfg_wr;

  logic                push, pop, q_full, q_empty;
  logic [CW-1:0]       push_col;
  logic [RW-1:0]       push_row;
  lss_pkg::lss_flags_t push_flags;
  logic [QW-1:0]       q_rdata;

  // Register file: writes land in the access phase, reads are immediate.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= lss_pkg::CFG_RESET;
      grid_rows_r <= lss_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[lss_pkg::REG_SEL_B])
        lss_pkg::REG_GRID_COLS: grid_cols_r <= pwdata[lss_pkg::CFG_W-1:0];
        lss_pkg::REG_GRID_ROWS: grid_rows_r <= pwdata[lss_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[lss_pkg::REG_SEL_B])
      lss_pkg::REG_GRID_COLS: prdata = lss_pkg::BUS_W'(grid_cols_r);
      lss_pkg::REG_GRID_ROWS: prdata = lss_pkg::BUS_W'(grid_rows_r);
      default:                prdata = '0;
    endcase
  end

  // Front end: raster position and end-of-grid flag for each beat.
  lss_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cols_cfg     (grid_cols_r),
    .rows_cfg     (grid_rows_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_open (in_cell_open),
    .q_full       (q_full),
    .push         (push),
    .push_col     (push_col),
    .push_row     (push_row),
    .push_flags   (push_flags)
  );

  // Queue between the two halves.
  lss_queue #(
    .WIDTH (QW),
    .DEPTH (lss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_row, push_col}),
    .pop       (pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: recurrence, best tracking and output register.
  lss_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (pop),
    .q_col           (q_rdata[CW-1:0]),
    .q_row           (q_rdata[CW +: RW]),
    .q_flags         (lss_pkg::lss_flags_t'(q_rdata[QW-1 -: FW])),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_square (out_cell_square),
    .out_best_size   (out_best_size),
    .out_best_row    (out_best_row),
    .out_best_col    (out_best_col),
    .out_grid_done   (out_grid_done)
  );

endmodule

// File: test/tb_largest_square_scan.sv
`timescale 1ns / 100ps
// Self-checking testbench for largest_square_scan: streams grids of cells and checks every
// result beat against a cycle-free square predictor. Depends on lss_pkg and the RTL only.
module tb_largest_square_scan;

  localparam int MAX_COLS = lss_pkg::DEF_MAX_COLS;
  localparam int MAX_ROWS = lss_pkg::DEF_MAX_ROWS;

  typedef struct packed {
    logic [lss_pkg::CELL_W-1:0] cell_square;
    logic [lss_pkg::CELL_W-1:0] best_size;
    logic [lss_pkg::POS_W-1:0]  best_row;
    logic [lss_pkg::POS_W-1:0]  best_col;
    logic                       grid_done;
  } square_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lss_pkg::ADDR_W-1:0]  paddr = '0;
  logic [lss_pkg::BUS_W-1:0]   pwdata = '0;
  logic [lss_pkg::BUS_W-1:0]   prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_cell_open = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [lss_pkg::CELL_W-1:0]  out_cell_square;
  logic [lss_pkg::CELL_W-1:0]  out_best_size;
  logic [lss_pkg::POS_W-1:0]   out_best_row;
  logic [lss_pkg::POS_W-1:0]   out_best_col;
  logic                        out_grid_done;

  largest_square_scan dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_open(in_cell_open),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_square(out_cell_square), .out_best_size(out_best_size),
    .out_best_row(out_best_row), .out_best_col(out_best_col), .out_grid_done(out_grid_done)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage.
  logic         cell_queue[$];
  square_beat_t square_expect[$];
  logic         in_taken = 1'b0;
  int           send_idle_pct = 29;
  int           recv_stall_pct = 76;
  int           mismatch_count = 0;
  int           out_beats = 0;

  // Predictor copy of the size registers and the scan state.
  logic [lss_pkg::CFG_W-1:0]  cols_cfg = lss_pkg::CFG_RESET;
  logic [lss_pkg::CFG_W-1:0]  rows_cfg = lss_pkg::CFG_RESET;
  logic [lss_pkg::CELL_W-1:0] line_vals [0:MAX_COLS-1];
  logic [lss_pkg::CELL_W-1:0] left_val = '0;
  logic [lss_pkg::CELL_W-1:0] diag_val = '0;
  logic [lss_pkg::CELL_W-1:0] best_val = '0;
  logic [lss_pkg::POS_W-1:0]  best_r = '0;
  logic [lss_pkg::POS_W-1:0]  best_c = '0;
  int                         col_pos = 0;
  int                         row_pos = 0;
  // Line-buffer entries below this column have been written since reset.
  int                         lines_valid = 0;

  // Long receiver hold-off, so the internal queue fills and the input stalls.
  logic stall_hold = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  initial begin
    for (int i = 0; i < MAX_COLS; i++) line_vals[i] = '0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: result beat %0d: %s is %0d, expected %0d", out_beats, field, got, want);
    mismatch_count++;
  endtask

  // A size of zero acts as one and anything above the maximum acts as the maximum.
  function automatic int eff_size(input logic [lss_pkg::CFG_W-1:0] v, input int max);
    if (v == 0) return 1;
    if (v > max) return max;
    return int'(v);
  endfunction

  function automatic int cells_to_grid_end();
    int cols, rows, c, r;
    cols = eff_size(cols_cfg, MAX_COLS);
    rows = eff_size(rows_cfg, MAX_ROWS);
    c = col_pos;
    r = row_pos;
    if (c >= cols) begin
      c = 0;
      r++;
    end
    if (r >= rows) r = 0;
    return cols * rows - (r * cols + c);
  endfunction

  // Advances the scan by one cell and returns the result beat it produces.
  function automatic square_beat_t step_square(input logic open);
    int cols, rows, col, row;
    logic [lss_pkg::CELL_W-1:0] up, val, low;
    square_beat_t beat;
    cols = eff_size(cols_cfg, MAX_COLS);
    rows = eff_size(rows_cfg, MAX_ROWS);
    // Sizes shrunk mid-grid push the position onto the next row or back to row 0.
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    col = col_pos;
    row = row_pos;

    up = line_vals[col];
    if (!open) begin
      val = '0;
    end else if (row == 0 || col == 0) begin
      val = lss_pkg::CELL_W'(1);
    end else begin
      low = left_val;
      if (diag_val < low) low = diag_val;
      if (up < low) low = up;
      val = (low == lss_pkg::CELL_MAX) ? lss_pkg::CELL_MAX : low + 1'b1;
    end
    diag_val = up;
    left_val = val;
    line_vals[col] = val;
    if (col >= lines_valid) lines_valid = col + 1;

    // Only a strictly larger value moves the best corner.
    if (val > best_val) begin
      best_val = val;
      best_r = lss_pkg::POS_W'(row);
      best_c = lss_pkg::POS_W'(col);
    end
    beat.cell_square = val;
    beat.best_size = best_val;
    beat.best_row = best_r;
    beat.best_col = best_c;
    beat.grid_done = (row == rows - 1) && (col == cols - 1);

    col_pos = col + 1;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= rows) row_pos = 0;
    end
    if (beat.grid_done) begin
      col_pos = 0;
      row_pos = 0;
      best_val = '0;
      best_r = '0;
      best_c = '0;
    end
    return beat;
  endfunction

  // Input driver: presents the next cell once the current beat is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (cell_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_cell_open <= cell_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_cell_open <= 1'($urandom_range(1));
      end
    end
  end

  // Result receiver: random stalls plus the long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= stall_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The hold-off fires once, while more cells are waiting than the block can hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_hold <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (stall_hold) begin
      if (hold_left == 0) stall_hold <= 1'b0;
      else hold_left <= hold_left - 1;
    end else if (!hold_done && cell_queue.size() > 6) begin
      stall_hold <= 1'b1;
      hold_left <= 63;
      hold_done <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted cell beat, checks each accepted result beat.
  always @(posedge clk) begin
    square_beat_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) square_expect.push_back(step_square(in_cell_open));
      if (out_valid && !out_stall) begin
        if (square_expect.size() == 0) begin
          report_mismatch("beat with nothing expected, cell_square", 32'(out_cell_square), 0);
        end else begin
          want = square_expect.pop_front();
          if (out_cell_square !== want.cell_square)
            report_mismatch("cell_square", 32'(out_cell_square), 32'(want.cell_square));
          if (out_best_size !== want.best_size)
            report_mismatch("best_size", 32'(out_best_size), 32'(want.best_size));
          if (out_best_row !== want.best_row)
            report_mismatch("best_row", 32'(out_best_row), 32'(want.best_row));
          if (out_best_col !== want.best_col)
            report_mismatch("best_col", 32'(out_best_col), 32'(want.best_col));
          if (out_grid_done !== want.grid_done)
            report_mismatch("grid_done", 32'(out_grid_done), 32'(want.grid_done));
        end
        out_beats++;
      end
    end
  end

  // Returns once every cell has gone in and every result has come out.
  task automatic wait_idle();
    do @(posedge clk);
    while (cell_queue.size() != 0 || in_valid || square_expect.size() != 0);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_size(input logic sel, input logic [lss_pkg::CFG_W-1:0] value);
    logic [lss_pkg::BUS_W-1:0] data;
    data = $urandom;
    data[lss_pkg::CFG_W-1:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lss_pkg::ADDR_W'(sel) << lss_pkg::REG_SEL_B;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (sel == lss_pkg::REG_GRID_COLS) cols_cfg = value;
    else rows_cfg = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Queues n cells, LSB first.
  task automatic queue_bits(input logic [31:0] bits, input int n);
    for (int i = 0; i < n; i++) cell_queue.push_back(bits[i]);
  endtask

  // Queues n cells: blocked up to lead, then open with the given percentage.
  task automatic queue_grid(input int n, input int open_pct, input int lead);
    for (int i = 0; i < n; i++)
      cell_queue.push_back((i >= lead) && ($urandom_range(99) < open_pct));
  endtask

  initial begin
    int random_cells;
    int n;
    int pct;
    logic [lss_pkg::CFG_W-1:0] size_val;
    random_cells = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Start a grid at the reset sizes, then shrink it mid-grid to 4 x 3 and finish it
    // all open, which ends on a tie that must not move the best corner.
    queue_bits(32'b111, 3);
    wait_idle();
    write_size(lss_pkg::REG_GRID_COLS, 11'd4);
    write_size(lss_pkg::REG_GRID_ROWS, 11'd3);
    queue_bits(32'b1_1111_1111, 9);
    wait_idle();

    // Zero sizes act as a 1 x 1 grid: every cell is a whole grid.
    write_size(lss_pkg::REG_GRID_COLS, 11'd0);
    write_size(lss_pkg::REG_GRID_ROWS, 11'd0);
    queue_bits(32'b110, 3);
    wait_idle();

    // 3 x 3 grid cut to one column mid-grid: the next cell moves to the next row.
    write_size(lss_pkg::REG_GRID_COLS, 11'd3);
    write_size(lss_pkg::REG_GRID_ROWS, 11'd3);
    queue_bits(32'b1011, 4);
    wait_idle();
    write_size(lss_pkg::REG_GRID_COLS, 11'd1);
    queue_bits(32'b01, 2);
    wait_idle();

    // Two columns, then the row count drops below the current row: back to row 0,
    // with the best corner kept.
    write_size(lss_pkg::REG_GRID_COLS, 11'd2);
    write_size(lss_pkg::REG_GRID_ROWS, 11'd4);
    queue_bits(32'b1101, 4);
    wait_idle();
    write_size(lss_pkg::REG_GRID_ROWS, 11'd2);
    queue_bits(32'b1111, 4);

    // Random grids of small sizes, some cut short and resized mid-grid.
    while (random_cells < 260) begin
      wait_idle();
      if (random_cells >= 130) begin
        send_idle_pct = 76;
        recv_stall_pct = 29;
      end
      if ($urandom_range(3) != 0) begin
        size_val = lss_pkg::CFG_W'($urandom_range(16));
        // Mid-grid, the column count may only grow over line-buffer entries already written.
        if (!(col_pos == 0 && row_pos == 0) && eff_size(size_val, MAX_COLS) > lines_valid)
          size_val = lss_pkg::CFG_W'($urandom_range(lines_valid, 1));
        write_size(lss_pkg::REG_GRID_COLS, size_val);
      end
      if ($urandom_range(3) != 0)
        write_size(lss_pkg::REG_GRID_ROWS, lss_pkg::CFG_W'($urandom_range(6)));
      n = cells_to_grid_end();
      if ($urandom_range(4) == 0) n = $urandom_range(n, 1);
      case ($urandom_range(5))
        0: pct = 0;
        1: pct = 40;
        2: pct = 70;
        3: pct = 90;
        default: pct = 100;
      endcase
      queue_grid(n, pct, 0);
      random_cells += n;
    end

    // Finish the current grid, then short runs with over-range sizes, at full rate.
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_grid(cells_to_grid_end(), 80, 0);
    wait_idle();
    write_size(lss_pkg::REG_GRID_COLS, 11'd2047);
    write_size(lss_pkg::REG_GRID_ROWS, 11'd1);
    queue_grid(24, 90, 4);
    wait_idle();
    write_size(lss_pkg::REG_GRID_COLS, 11'd1);
    write_size(lss_pkg::REG_GRID_ROWS, 11'd2047);
    queue_grid(24, 90, 4);
    wait_idle();

    // Let any stray result beat show up before the verdict.
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
